FILE: hw/rtl/kbm_pkg.sv
// ----------------------------------------------------------------------------
// kbm_pkg: key binding table shared types and constants
// Field widths, command codes, the input and result item structs, and the
// token that walks the row of binding cells during a lookup.
// ----------------------------------------------------------------------------
package kbm_pkg;

  localparam int SLOT_W  = 6;
  localparam int KEY_W   = 25;
  localparam int MOD_W   = 5;
  localparam int STATE_W = 6;
  localparam int CMDC_W  = 3;
  localparam int TEXT_W  = 16;

  // slots reachable through the 6-bit slot field
  localparam int SLOT_RANGE = 2 ** SLOT_W;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [MOD_W-1:0]   mod_t;
  typedef logic [STATE_W-1:0] state_t;
  typedef logic [CMDC_W-1:0]  cmdc_t;
  typedef logic [TEXT_W-1:0]  text_t;

  // item command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_WRITE  = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  // keypad modifier bit and any-modifier state bit
  localparam mod_t   MOD_KEYPAD = 5'h10;
  localparam state_t ST_ANYMOD  = 6'h10;
  localparam int     ST_ANYMOD_BIT = 4;

  typedef struct packed {
    cmd_t   cmd;
    slot_t  slot;
    key_t   key_code;
    mod_t   modifiers;
    mod_t   modifier_mask;
    state_t state_bits;
    state_t state_mask;
    cmdc_t  command_code;
    text_t  text_handle;
  } in_item_t;

  typedef struct packed {
    logic  hit;
    slot_t match_slot;
    cmdc_t result_command;
    text_t result_text;
  } out_item_t;

  // lookup query plus the best result found so far
  typedef struct packed {
    key_t      key_code;
    mod_t      modifiers;
    state_t    state_bits;
    out_item_t res;
  } tok_body_t;

  typedef struct packed {
    logic      valid;
    tok_body_t body;
  } token_t;

endpackage

FILE: hw/rtl/kbm_cell.sv
// ----------------------------------------------------------------------------
// kbm_cell: one binding slot of the key binding table
// Holds one binding and its valid bit. A lookup token passes through each
// cycle; the first valid matching cell along the row stamps its result.
// ----------------------------------------------------------------------------
module kbm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic              clr_en,
  input  kbm_pkg::in_item_t wr_item,
  input  kbm_pkg::slot_t    cell_slot,
  input  kbm_pkg::token_t   tok_in,
  output kbm_pkg::token_t   tok_out
);

  logic                valid_r;
  logic                valid_nxt;
  kbm_pkg::key_t       key_r;
  kbm_pkg::mod_t       mods_r;
  kbm_pkg::mod_t       mmask_r;
  kbm_pkg::state_t     st_r;
  kbm_pkg::state_t     smask_r;
  kbm_pkg::cmdc_t      cmdc_r;
  kbm_pkg::text_t      text_r;

  logic                tok_valid_r;
  kbm_pkg::tok_body_t  tok_body_r;
  kbm_pkg::tok_body_t  tok_body_nxt;

  logic                mods_any;
  logic                any_set;
  kbm_pkg::state_t     tst;
  logic                match;

  // valid bit: write sets, clear drops
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt = 1'b1;
    end else if (clr_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // binding storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r   <= wr_item.key_code;
      mods_r  <= wr_item.modifiers;
      mmask_r <= wr_item.modifier_mask;
      st_r    <= wr_item.state_bits;
      smask_r <= wr_item.state_mask;
      cmdc_r  <= wr_item.command_code;
      text_r  <= wr_item.text_handle;
    end
  end

  // masked match against the passing query
  always_comb begin
    mods_any = (tok_in.body.modifiers != '0);
    any_set  = mods_any && (tok_in.body.modifiers != kbm_pkg::MOD_KEYPAD);
    tst      = tok_in.body.state_bits | (mods_any ? kbm_pkg::ST_ANYMOD : '0);
    match    = valid_r
            && (key_r == tok_in.body.key_code)
            && ((tok_in.body.modifiers & mmask_r) == (mods_r & mmask_r))
            && ((tst & smask_r) == (st_r & smask_r))
            && (!smask_r[kbm_pkg::ST_ANYMOD_BIT]
                || (st_r[kbm_pkg::ST_ANYMOD_BIT] == any_set));
  end

  // first match along the row wins
  always_comb begin
    tok_body_nxt = tok_in.body;
    if (!tok_in.body.res.hit && match) begin
      tok_body_nxt.res.hit            = 1'b1;
      tok_body_nxt.res.match_slot     = cell_slot;
      tok_body_nxt.res.result_command = cmdc_r;
      tok_body_nxt.res.result_text    = text_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_body_r <= tok_body_nxt;
  end

  assign tok_out.valid = tok_valid_r;
  assign tok_out.body  = tok_body_r;

endmodule

FILE: hw/rtl/key_binding_masked_match_table_core.sv
// ----------------------------------------------------------------------------
// key_binding_masked_match_table_core: key binding table with masked match
// A row of SLOTS binding cells. Writes and clears go straight to the
// addressed cell; a lookup token walks the row one cell per cycle and
// picks up the lowest matching slot.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+--------------------------------
//   input    | start, busy, in_item   | taken when start && !busy
//   result   | out_valid, out_item    | one-cycle strobe, no back-pressure
//
// Write, clear or unused command: result strobes the cycle after the item
// is taken; the next item can be taken in the cycle after the strobe.
// Lookup: the token is registered in each cell of the row in turn, and the
// result strobes as it leaves the last cell; busy holds off the next item.
// Reset empties all slots at once through the per-slot valid bits.
// The receiver cannot stall; busy is the only hold on the input side.
// ----------------------------------------------------------------------------
module key_binding_masked_match_table_core #(
  parameter int SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kbm_pkg::in_item_t  in_item,
  output logic               out_valid,
  output kbm_pkg::out_item_t out_item
);

  logic            accept;
  logic            busy_r;
  logic            busy_nxt;
  logic            done_r;
  logic            done_nxt;
  kbm_pkg::token_t tok [SLOTS+1];
  logic [SLOTS-1:0] tok_valids;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // launch token into the first cell
  assign tok[0].valid           = accept && (in_item.cmd == kbm_pkg::CMD_LOOKUP);
  assign tok[0].body.key_code   = in_item.key_code;
  assign tok[0].body.modifiers  = in_item.modifiers;
  assign tok[0].body.state_bits = in_item.state_bits;
  assign tok[0].body.res        = '0;

  // row of binding cells
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic wr_en;
    logic clr_en;

    if (k < kbm_pkg::SLOT_RANGE) begin : g_addr
      assign wr_en  = accept && (in_item.cmd == kbm_pkg::CMD_WRITE)
                   && (in_item.slot == kbm_pkg::slot_t'(k));
      assign clr_en = accept && (in_item.cmd == kbm_pkg::CMD_CLEAR)
                   && (in_item.slot == kbm_pkg::slot_t'(k));
    end else begin : g_noaddr
      assign wr_en  = 1'b0;
      assign clr_en = 1'b0;
    end

    kbm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en),
      .clr_en    (clr_en),
      .wr_item   (in_item),
      .cell_slot (kbm_pkg::slot_t'(k)),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1])
    );

    assign tok_valids[k] = tok[k+1].valid;
  end

  // non-lookup items answer with an all-zero result next cycle
  assign done_nxt = accept && (in_item.cmd != kbm_pkg::CMD_LOOKUP);

  // busy from accept until the result strobe
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (out_valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // result port
  assign out_valid = done_r || tok[SLOTS].valid;
  assign out_item  = tok[SLOTS].valid ? tok[SLOTS].body.res : '0;

  // checks
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("busy not raised after item taken");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({tok_valids, done_r}) <= 1)
    else $error("more than one item in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> (out_item == '0))
    else $error("miss result not all zero");

endmodule
